/* sv/mt32_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt32_pkg
// Shared types, constants and word functions of the 32-bit Mersenne twister.
// ----------------------------------------------------------------------------
package mt32_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int ADDR_W       = $clog2(STATE_WORDS);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [31:0]       word_t;

  // Operation codes of an input transfer.
  typedef enum logic [0:0] {
    OP_DRAW   = 1'b0,
    OP_RESEED = 1'b1
  } op_t;

  localparam addr_t LAST_ADDR    = addr_t'(STATE_WORDS - 1);
  localparam word_t DEFAULT_SEED = 32'd5489;
  localparam word_t INIT_MULT    = 32'h6c078965;
  localparam word_t TWIST_MATRIX = 32'h9908b0df;
  localparam word_t UPPER_MASK   = 32'h80000000;
  localparam word_t LOWER_MASK   = 32'h7fffffff;
  localparam word_t TEMPER_B     = 32'h9d2c5680;
  localparam word_t TEMPER_C     = 32'hefc60000;

  // One write into the state memory.
  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } mem_wr_t;

  // Adds an offset below the table size and wraps around the table.
  function automatic addr_t addr_add(addr_t base, addr_t offs);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (ADDR_W+1)'(STATE_WORDS)) begin
      sum = sum - (ADDR_W+1)'(STATE_WORDS);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // New value of one state word from the word, its successor and the far word.
  function automatic word_t twist_word(word_t cur, word_t nxt, word_t far);
    word_t y;
    word_t v;
    y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  function automatic word_t temper(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* sv/mersenne_twister_32bit_top.sv */
`timescale 1ns / 1ps
// A draw shows its word on out_valid in the cycle after the transfer.
// One draw per cycle unless stalled; each draw twists a state word in memory.
// A reseed holds in_stall while the sequencer writes the state.
// Reset starts the same seeding pass with seed 5489; the input is
// stalled until it ends.
// ----------------------------------------------------------------------------
// mersenne_twister_32bit_top
// MT19937 generator with the state in a two-read-port memory.
// ----------------------------------------------------------------------------
module mersenne_twister_32bit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [0:0]  in_operation,
  input  logic [31:0] in_seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_random_word
);

  localparam mt32_pkg::addr_t ONE_ADDR = mt32_pkg::addr_t'(1);
  localparam mt32_pkg::addr_t FAR_ADDR = mt32_pkg::addr_t'(mt32_pkg::TWIST_OFFSET);

  logic              seed_busy;
  mt32_pkg::mem_wr_t seed_wr;
  mt32_pkg::mem_wr_t mem_wr;
  mt32_pkg::word_t   rd_a_data;
  mt32_pkg::word_t   rd_b_data;
  mt32_pkg::word_t   twisted;

  logic            accept;
  logic            draw;
  logic            reseed;
  mt32_pkg::addr_t pos_r;
  mt32_pkg::addr_t pos_nxt;
  mt32_pkg::word_t cur_r;
  mt32_pkg::word_t cur_nxt;
  logic            out_valid_r;
  mt32_pkg::word_t out_word_r;

  assign in_stall = seed_busy || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign draw     = accept && (in_operation == mt32_pkg::OP_DRAW);
  assign reseed   = accept && (in_operation == mt32_pkg::OP_RESEED);

  // cur_r holds the untwisted word at pos_r; the memory outputs hold its
  // successor and the word one twist offset ahead, read for pos_r.
  assign twisted = mt32_pkg::twist_word(cur_r, rd_a_data, rd_b_data);

  always_comb begin
    pos_nxt = pos_r;
    cur_nxt = cur_r;
    if (draw) begin
      pos_nxt = (pos_r == mt32_pkg::LAST_ADDR) ? '0 : pos_r + 1'b1;
      cur_nxt = rd_a_data;
    end else if (reseed) begin
      pos_nxt = '0;
      cur_nxt = in_seed_value;
    end
  end

  always_comb begin
    if (seed_wr.en) begin
      mem_wr = seed_wr;
    end else begin
      mem_wr.en   = draw;
      mem_wr.addr = pos_r;
      mem_wr.data = twisted;
    end
  end

  mt32_seed u_seed (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (reseed),
    .start_seed (in_seed_value),
    .busy       (seed_busy),
    .wr         (seed_wr)
  );

  mt32_ram u_ram (
    .clk       (clk),
    .wr        (mem_wr),
    .rd_a_addr (mt32_pkg::addr_add(pos_nxt, ONE_ADDR)),
    .rd_b_addr (mt32_pkg::addr_add(pos_nxt, FAR_ADDR)),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cur_r       <= mt32_pkg::DEFAULT_SEED;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      cur_r <= cur_nxt;
      if (draw) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (draw) begin
      out_word_r <= mt32_pkg::temper(twisted);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

endmodule

/* sv/mt32_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt32_ram
// State memory: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module mt32_ram (
  input  logic             clk,
  input  mt32_pkg::mem_wr_t wr,
  input  mt32_pkg::addr_t  rd_a_addr,
  input  mt32_pkg::addr_t  rd_b_addr,
  output mt32_pkg::word_t  rd_a_data,
  output mt32_pkg::word_t  rd_b_data
);

  mt32_pkg::word_t mem [mt32_pkg::STATE_WORDS];
  mt32_pkg::word_t rd_a_r;
  mt32_pkg::word_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;

endmodule

/* sv/mt32_seed.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt32_seed
// Seeding sequencer: writes one word of the initialization recurrence per cycle.
// ----------------------------------------------------------------------------
module mt32_seed (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mt32_pkg::word_t   start_seed,
  output logic              busy,
  output mt32_pkg::mem_wr_t wr
);

  logic            busy_r;
  logic            busy_nxt;
  mt32_pkg::addr_t cnt_r;
  mt32_pkg::addr_t cnt_nxt;
  mt32_pkg::word_t prev_r;
  mt32_pkg::word_t prev_nxt;
  mt32_pkg::word_t mix;
  mt32_pkg::word_t prod;
  mt32_pkg::word_t word;

  assign mix  = prev_r ^ (prev_r >> 30);
  assign prod = mt32_pkg::INIT_MULT * mix;
  // The first word is the seed itself.
  assign word = (cnt_r == '0) ? prev_r
                              : prod + {{(32-mt32_pkg::ADDR_W){1'b0}}, cnt_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    prev_nxt = prev_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      prev_nxt = start_seed;
    end else if (busy_r) begin
      prev_nxt = word;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == mt32_pkg::LAST_ADDR) begin
        busy_nxt = 1'b0;
        cnt_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      prev_r <= mt32_pkg::DEFAULT_SEED;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      prev_r <= prev_nxt;
    end
  end

  assign busy    = busy_r;
  assign wr.en   = busy_r;
  assign wr.addr = cnt_r;
  assign wr.data = word;

endmodule
